@@ rtl/rlpf_pkg.sv @@
// Shared types, constants and byte tables of the RC link packet framer.
package rlpf_pkg;

   // Stick scaling: clamp to +/- full scale, then magnitude * 127 / full scale.
   localparam int FULL_SCALE    = 10000;
   localparam int STICK_W       = 16;
   localparam int STICK_N       = 4;
   localparam int MAG_W         = 7;
   localparam int CLAMP_W       = $clog2(FULL_SCALE + 1);
   localparam int PROD_IN_W     = CLAMP_W + MAG_W;
   localparam int SCALE_SHIFT   = 35;
   localparam longint unsigned SCALE_RECIP =
      ((64'd1 << SCALE_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
   localparam int RECIP_W       = $clog2(SCALE_RECIP + 1);
   localparam int PROD_W        = PROD_IN_W + RECIP_W;

   // Link sequencing.
   localparam int BIND_PACKETS  = 345;
   localparam int CD_W          = 9;
   localparam int TABLE_DEPTH   = 16;
   localparam int TBL_AW        = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

   // Packet geometry.
   localparam int PKT_MAX       = 16;
   localparam int LEN_W         = $clog2(PKT_MAX + 1);
   localparam int FIRST_LEN     = 15;
   localparam int SHORT_LEN     = 10;
   localparam int X5C_LEN       = 16;
   localparam int ADDR_W        = 40;
   localparam int CHAN_W        = 7;
   localparam int FLAG_W        = 3;

   localparam logic [CHAN_W-1:0] FIRST_CHANNEL = 7'd8;
   localparam logic [7:0] CK_OFFSET   = 8'h55;
   localparam logic [7:0] X5C_MARK_A  = 8'hae;
   localparam logic [7:0] X5C_MARK_B  = 8'ha9;
   localparam logic [7:0] X5C_BIND_A  = 8'hc0;
   localparam logic [7:0] X5C_BIND_B  = 8'h17;
   localparam logic [7:0] BIND_FILL   = 8'haa;
   localparam logic [7:0] TRIM_BIAS   = 8'h20;
   localparam logic [7:0] CENTER      = 8'h80;
   localparam logic [31:0] ADDR_WORD_1E = 32'h38184121;
   localparam logic [31:0] ADDR_WORD_1F = 32'h39194121;

   // Hop table sizes of each load.
   localparam logic [CNT_W-1:0] CNT_BIND_SHORT = CNT_W'(4);
   localparam logic [CNT_W-1:0] CNT_BIND_X5C   = CNT_W'(16);
   localparam logic [CNT_W-1:0] CNT_DATA_X5C   = CNT_W'(15);
   localparam logic [CNT_W-1:0] CNT_ADDR       = CNT_W'(4);

   localparam logic [7:0] FIRST_BYTES [FIRST_LEN] = '{
      8'hf9, 8'h96, 8'h82, 8'h1b, 8'h20, 8'h08, 8'h08, 8'hf2,
      8'h7d, 8'hef, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] BIND_HOPS [4] = '{8'h4b, 8'h30, 8'h40, 8'h2e};
   localparam logic [7:0] BIND_HOPS_X5C [16] = '{
      8'h27, 8'h1b, 8'h39, 8'h28, 8'h24, 8'h22, 8'h2e, 8'h36,
      8'h19, 8'h21, 8'h29, 8'h14, 8'h1e, 8'h12, 8'h2d, 8'h18};
   localparam logic [7:0] DATA_HOPS_X5C [15] = '{
      8'h1d, 8'h2f, 8'h26, 8'h3d, 8'h15, 8'h2b, 8'h25, 8'h24,
      8'h27, 8'h2c, 8'h1c, 8'h3e, 8'h39, 8'h2d, 8'h22};
   localparam logic [7:0] BASE_LO  [4] = '{8'h0a, 8'h1a, 8'h2a, 8'h3a};
   localparam logic [7:0] BASE_MID [4] = '{8'h2a, 8'h0a, 8'h42, 8'h22};
   localparam logic [7:0] BASE_HI  [4] = '{8'h1a, 8'h3a, 8'h12, 8'h32};

   // Link phases.
   typedef enum logic [3:0] {
      PH_FIRST      = 4'b0001,
      PH_BIND_START = 4'b0010,
      PH_BIND       = 4'b0100,
      PH_DATA       = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FIRST = 2'd0,
      KIND_BIND  = 2'd1,
      KIND_DATA  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SRC_BIND_SHORT = 2'd0,
      SRC_BIND_X5C   = 2'd1,
      SRC_DATA_X5C   = 2'd2,
      SRC_ADDR       = 2'd3
   } tbl_src_type;

   typedef enum logic [1:0] {
      CSR_MODE  = 2'd0,
      CSR_FLAGS = 2'd1,
      CSR_ADDR  = 2'd2
   } csr_index_type;

   // Hop table load request.
   typedef struct packed {
      logic        valid;
      tbl_src_type src;
      logic [4:0]  addr_lo;
   } load_req_type;

   // Everything the packet builder needs besides the stick bytes.
   typedef struct packed {
      kind_type           kind;
      logic [CHAN_W-1:0]  chan;
      logic               mode;
      logic [FLAG_W-1:0]  flags;
      logic [ADDR_W-1:0]  addr;
   } build_req_type;

   function automatic logic [7:0] throttle_map(input logic [7:0] b);
      return b[7] ? (8'hff - b) : (CENTER + b);
   endfunction

   function automatic logic [7:0] trim_map(input logic [7:0] x);
      logic [7:0] y;
      y = x[7] ? (8'hff - x) : (CENTER + x);
      return {2'b00, y[7:2]} + TRIM_BIAS;
   endfunction

endpackage

@@ rtl/rlpf_hop_table.sv @@
// Hop channel memory with its load sweep and registered read port.
module rlpf_hop_table (
   input  logic                          clock,
   input  logic                          reset,
   input  rlpf_pkg::load_req_type        load_req,
   input  logic                          rd_en,
   input  logic [rlpf_pkg::TBL_AW-1:0]   rd_addr,
   output logic [7:0]                    rd_data,
   output logic                          busy
);

   logic [7:0]                   mem [rlpf_pkg::TABLE_DEPTH];
   logic [7:0]                   rd_data_ff;
   logic                         busy_ff, busy_in;
   logic [rlpf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [rlpf_pkg::CNT_W-1:0]   len_ff;
   rlpf_pkg::tbl_src_type        src_ff;
   logic [7:0]                   addr_hops_ff [4];
   logic [7:0]                   addr_hops_in [4];
   logic [7:0]                   wr_data;
   logic [4:0]                   a;
   logic [2:0]                   a_lo;

   // Data hop channels derived from the low five bits of address byte 0.
   always_comb begin
      a    = load_req.addr_lo;
      a_lo = a[2:0];
      for (int i = 0; i < 4; i++) begin
         addr_hops_in[i] = 8'h00;
      end
      if (a < 5'h10) begin
         for (int i = 0; i < 4; i++) begin
            addr_hops_in[i] = rlpf_pkg::BASE_LO[i] + ((a == 5'd6) ? 8'd7 : {3'b000, a});
         end
      end else if (a < 5'h18) begin
         for (int i = 0; i < 4; i++) begin
            addr_hops_in[i] = rlpf_pkg::BASE_MID[i] + {5'b00000, a_lo};
         end
         if (a == 5'h16) begin
            addr_hops_in[0] = addr_hops_in[0] + 8'd1;
            addr_hops_in[1] = addr_hops_in[1] + 8'd1;
         end
      end else if (a < 5'h1e) begin
         for (int i = 0; i < 4; i++) begin
            addr_hops_in[i] = rlpf_pkg::BASE_HI[i] + {5'b00000, a_lo};
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            addr_hops_in[i] = (a == 5'h1e) ? rlpf_pkg::ADDR_WORD_1E[8*i +: 8]
                                           : rlpf_pkg::ADDR_WORD_1F[8*i +: 8];
         end
      end
   end

   // Source byte for the current sweep entry.
   always_comb begin
      unique case (src_ff)
         rlpf_pkg::SRC_BIND_SHORT: wr_data = rlpf_pkg::BIND_HOPS[cnt_ff[1:0]];
         rlpf_pkg::SRC_BIND_X5C:   wr_data = rlpf_pkg::BIND_HOPS_X5C[cnt_ff[3:0]];
         rlpf_pkg::SRC_DATA_X5C:   wr_data = rlpf_pkg::DATA_HOPS_X5C[cnt_ff[3:0]];
         rlpf_pkg::SRC_ADDR:       wr_data = addr_hops_ff[cnt_ff[1:0]];
         default:                  wr_data = 8'h00;
      endcase
   end

   // Sweep control: one entry per cycle until the load length is reached.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (load_req.valid) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == len_ff - 1'b1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Load parameters are captured with the request.
   always_ff @(posedge clock) begin
      if (load_req.valid) begin
         src_ff <= load_req.src;
         addr_hops_ff <= addr_hops_in;
         unique case (load_req.src)
            rlpf_pkg::SRC_BIND_SHORT: len_ff <= rlpf_pkg::CNT_BIND_SHORT;
            rlpf_pkg::SRC_BIND_X5C:   len_ff <= rlpf_pkg::CNT_BIND_X5C;
            rlpf_pkg::SRC_DATA_X5C:   len_ff <= rlpf_pkg::CNT_DATA_X5C;
            rlpf_pkg::SRC_ADDR:       len_ff <= rlpf_pkg::CNT_ADDR;
            default:                  len_ff <= rlpf_pkg::CNT_ADDR;
         endcase
      end
   end

   // Memory: one write port for the sweep, one registered read port.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[cnt_ff[rlpf_pkg::TBL_AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

@@ rtl/rlpf_stick_scale.sv @@
// Four lanes that clamp and scale stick values to sign-magnitude bytes.
module rlpf_stick_scale (
   input  logic                                               clock,
   input  logic                                               en,
   input  logic [rlpf_pkg::STICK_N-1:0][rlpf_pkg::STICK_W-1:0] raw,
   output logic [rlpf_pkg::STICK_N-1:0][7:0]                   stick
);

   localparam logic signed [rlpf_pkg::STICK_W-1:0] POS_LIMIT =
      rlpf_pkg::STICK_W'(rlpf_pkg::FULL_SCALE);
   localparam logic signed [rlpf_pkg::STICK_W-1:0] NEG_LIMIT =
      -rlpf_pkg::STICK_W'(rlpf_pkg::FULL_SCALE);
   localparam logic [rlpf_pkg::RECIP_W-1:0] RECIP =
      rlpf_pkg::RECIP_W'(rlpf_pkg::SCALE_RECIP);

   logic [rlpf_pkg::STICK_N-1:0][7:0] stick_ff;

   for (genvar g = 0; g < rlpf_pkg::STICK_N; g++) begin : g_lane
      logic signed [rlpf_pkg::STICK_W-1:0] v;
      logic signed [rlpf_pkg::STICK_W-1:0] vc;
      logic [rlpf_pkg::STICK_W-1:0]        vneg;
      logic [rlpf_pkg::CLAMP_W-1:0]        mag;
      logic [rlpf_pkg::PROD_IN_W-1:0]      scaled;
      logic [rlpf_pkg::PROD_W-1:0]         prod;

      // Clamp, take the magnitude, times 127 by shift and subtract,
      // then divide by full scale through the reciprocal.
      always_comb begin
         v = raw[g];
         if (v > POS_LIMIT) begin
            vc = POS_LIMIT;
         end else if (v < NEG_LIMIT) begin
            vc = NEG_LIMIT;
         end else begin
            vc = v;
         end
         vneg   = -vc;
         mag    = vc[rlpf_pkg::STICK_W-1] ? vneg[rlpf_pkg::CLAMP_W-1:0]
                                          : vc[rlpf_pkg::CLAMP_W-1:0];
         scaled = {mag, {rlpf_pkg::MAG_W{1'b0}}} - {{rlpf_pkg::MAG_W{1'b0}}, mag};
         prod   = rlpf_pkg::PROD_W'(scaled) * rlpf_pkg::PROD_W'(RECIP);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stick_ff[g] <= {v[rlpf_pkg::STICK_W-1],
                            prod[rlpf_pkg::SCALE_SHIFT +: rlpf_pkg::MAG_W]};
         end
      end
   end

   assign stick = stick_ff;

endmodule

@@ rtl/rlpf_pkt_builder.sv @@
// Packet assembly with checksum and the byte serializer on the result side.
module rlpf_pkt_builder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  rlpf_pkg::build_req_type           req,
   input  logic [rlpf_pkg::STICK_N-1:0][7:0] stick,
   output logic                              load_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast
);

   logic [7:0]                  pk [rlpf_pkg::PKT_MAX];
   logic [rlpf_pkg::LEN_W-1:0]  len;
   logic [7:0]                  thr, rud, ele, ail, xsum, asum;
   logic [7:0]                  pkt_ff [rlpf_pkg::PKT_MAX];
   logic [rlpf_pkg::LEN_W-1:0]  rem_ff, rem_in;
   logic [rlpf_pkg::CHAN_W-1:0] chan_ff;
   rlpf_pkg::kind_type          kind_ff;
   logic                        fire, is_last, is_bind;

   assign thr = stick[0];
   assign rud = stick[1];
   assign ele = stick[2];
   assign ail = stick[3];
   assign is_bind = (req.kind == rlpf_pkg::KIND_BIND);

   // Build the packet image for the requested kind and layout.
   always_comb begin
      for (int i = 0; i < rlpf_pkg::PKT_MAX; i++) begin
         pk[i] = 8'h00;
      end
      xsum = 8'h00;
      asum = 8'h00;
      if (req.kind == rlpf_pkg::KIND_FIRST) begin
         for (int i = 0; i < rlpf_pkg::FIRST_LEN; i++) begin
            pk[i] = rlpf_pkg::FIRST_BYTES[i];
         end
         len = rlpf_pkg::LEN_W'(rlpf_pkg::FIRST_LEN);
      end else if (req.mode) begin
         pk[7] = rlpf_pkg::X5C_MARK_A;
         pk[8] = rlpf_pkg::X5C_MARK_B;
         if (is_bind) begin
            pk[14] = rlpf_pkg::X5C_BIND_A;
            pk[15] = rlpf_pkg::X5C_BIND_B;
         end else begin
            pk[0]  = rlpf_pkg::throttle_map(thr);
            pk[1]  = rud;
            pk[2]  = ele ^ rlpf_pkg::CENTER;
            pk[3]  = ail;
            pk[4]  = rlpf_pkg::trim_map(rud ^ rlpf_pkg::CENTER);
            pk[5]  = rlpf_pkg::trim_map(ele);
            pk[6]  = rlpf_pkg::trim_map(ail ^ rlpf_pkg::CENTER);
            pk[14] = {3'b000, req.flags[1], req.flags[2], 1'b1, 1'b0, req.flags[0]};
            // Plain sum as a balanced tree over the bytes that can be nonzero.
            asum = ((pk[0] + pk[1]) + (pk[2] + pk[3])) + ((pk[4] + pk[5]) + (pk[6] + pk[7]))
                 + (pk[8] + pk[14]);
            pk[15] = asum;
         end
         len = rlpf_pkg::LEN_W'(rlpf_pkg::X5C_LEN);
      end else begin
         if (is_bind) begin
            for (int i = 0; i < 5; i++) begin
               pk[i] = req.addr[8*(4-i) +: 8];
            end
            pk[5] = rlpf_pkg::BIND_FILL;
            pk[6] = rlpf_pkg::BIND_FILL;
            pk[7] = rlpf_pkg::BIND_FILL;
         end else begin
            pk[0] = rlpf_pkg::throttle_map(thr);
            pk[1] = ele;
            pk[2] = rud;
            pk[3] = ail;
            pk[4] = {req.flags[1], req.flags[2], 6'b000000};
            pk[5] = {2'b11, ele[7:2]};
            pk[6] = {2'b00, rud[7:2]} | {1'b0, req.flags[0], 6'b000000};
            pk[7] = {2'b00, ail[7:2]};
         end
         for (int i = 0; i < 9; i++) begin
            xsum = xsum ^ pk[i];
         end
         pk[9] = xsum + rlpf_pkg::CK_OFFSET;
         len = rlpf_pkg::LEN_W'(rlpf_pkg::SHORT_LEN);
      end
   end

   // Serializer: byte 0 is on the port, the image shifts down per transfer.
   assign fire       = rsp_tvalid && rsp_tready;
   assign is_last    = (rem_ff == rlpf_pkg::LEN_W'(1));
   assign load_ready = (rem_ff == '0) || (fire && is_last);

   always_comb begin
      rem_in = rem_ff;
      if (load) begin
         rem_in = len;
      end else if (fire) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pkt_ff  <= pk;
         chan_ff <= req.chan;
         kind_ff <= req.kind;
      end else if (fire) begin
         for (int i = 0; i < rlpf_pkg::PKT_MAX - 1; i++) begin
            pkt_ff[i] <= pkt_ff[i+1];
         end
      end
   end

   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_tdata  = {1'b0, chan_ff, pkt_ff[0]};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = is_last;

endmodule

@@ rtl/rc_link_packet_framer.sv @@
// Top level of the RC link packet framer: link phases, hop sequencing, registers.
//
// Each accepted tick produces one packet of 15 (first packet), 10 or 16 bytes,
// sent on the result channel one byte per cycle while the consumer is ready,
// except the changeover tick between bind and data, which sends nothing. A tick
// passes the scaling stage (hop memory read, then the stick multipliers) and then
// waits for the serializer, which loads the next packet in the cycle the previous
// last byte is taken, so the next tick can be accepted while the previous packet
// is still being sent. The hop table lives in a 16-entry single-port-write memory;
// every table load (after the first tick and at the changeover tick) sweeps it one
// entry per cycle, 4 to 16 entries, and no tick is accepted until that sweep is done.
module rc_link_packet_framer (
   input  logic        clock,
   input  logic        reset,
   // Tick input. tdata: throttle_in[15:0], rudder_in[31:16],
   // elevator_in[47:32], aileron_in[63:48].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // Packet bytes. tdata: payload_byte[7:0], rf_channel[14:8], zero[15].
   // tuser: packet_kind[1:0].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_wdata
);

   logic                                               mode_ff;
   logic [rlpf_pkg::FLAG_W-1:0]                        flags_ff;
   logic [rlpf_pkg::ADDR_W-1:0]                        addr_ff;
   rlpf_pkg::phase_type                                phase_ff, phase_in;
   logic [rlpf_pkg::CD_W-1:0]                          cd_ff, cd_in;
   logic [rlpf_pkg::TBL_AW-1:0]                        hop_ff, hop_in;
   logic                                               parity_ff, parity_in;
   logic [rlpf_pkg::CNT_W-1:0]                         count_ff, count_in;
   logic [rlpf_pkg::CNT_W-1:0]                         hop_next;
   logic                                               a_busy_ff, a_busy_in;
   logic                                               a_done_ff, a_done_in;
   rlpf_pkg::kind_type                                 a_kind_ff, a_kind_in;
   logic [rlpf_pkg::STICK_N-1:0][rlpf_pkg::STICK_W-1:0] raw_ff;
   logic [rlpf_pkg::STICK_N-1:0][7:0]                  stick;
   rlpf_pkg::load_req_type                             load_req;
   rlpf_pkg::build_req_type                            build_req;
   logic                                               req_fire, do_send, rd_en;
   logic                                               tbl_busy, load_ready, b_load;
   logic [7:0]                                         rd_data;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         flags_ff <= '0;
         addr_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rlpf_pkg::CSR_MODE) begin
            mode_ff <= csr_wdata[0];
         end
         if (csr_index == rlpf_pkg::CSR_FLAGS) begin
            flags_ff <= csr_wdata[rlpf_pkg::FLAG_W-1:0];
         end
         if (csr_index == rlpf_pkg::CSR_ADDR) begin
            addr_ff <= csr_wdata;
         end
      end
   end

   assign req_tready = !a_busy_ff && !tbl_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign hop_next   = {1'b0, hop_ff} + 1'b1;

   // Phase sequencing, hop stepping and table loads on each accepted tick.
   always_comb begin
      phase_in  = phase_ff;
      cd_in     = cd_ff;
      hop_in    = hop_ff;
      parity_in = parity_ff;
      count_in  = count_ff;
      a_kind_in = a_kind_ff;
      do_send   = 1'b0;
      load_req  = '0;
      load_req.addr_lo = addr_ff[4:0];
      if (req_fire) begin
         unique case (phase_ff)
            rlpf_pkg::PH_FIRST: begin
               load_req.valid = 1'b1;
               load_req.src   = mode_ff ? rlpf_pkg::SRC_BIND_X5C : rlpf_pkg::SRC_BIND_SHORT;
               count_in  = mode_ff ? rlpf_pkg::CNT_BIND_X5C : rlpf_pkg::CNT_BIND_SHORT;
               hop_in    = '0;
               parity_in = 1'b0;
               a_kind_in = rlpf_pkg::KIND_FIRST;
               phase_in  = rlpf_pkg::PH_BIND_START;
            end
            rlpf_pkg::PH_BIND_START: begin
               cd_in     = rlpf_pkg::CD_W'(rlpf_pkg::BIND_PACKETS);
               a_kind_in = rlpf_pkg::KIND_BIND;
               do_send   = 1'b1;
               phase_in  = rlpf_pkg::PH_BIND;
            end
            rlpf_pkg::PH_BIND: begin
               if (cd_ff == '0) begin
                  load_req.valid = 1'b1;
                  load_req.src   = mode_ff ? rlpf_pkg::SRC_DATA_X5C : rlpf_pkg::SRC_ADDR;
                  count_in  = mode_ff ? rlpf_pkg::CNT_DATA_X5C : rlpf_pkg::CNT_ADDR;
                  hop_in    = '0;
                  parity_in = 1'b0;
                  phase_in  = rlpf_pkg::PH_DATA;
               end else begin
                  cd_in     = cd_ff - 1'b1;
                  a_kind_in = rlpf_pkg::KIND_BIND;
                  do_send   = 1'b1;
               end
            end
            rlpf_pkg::PH_DATA: begin
               a_kind_in = rlpf_pkg::KIND_DATA;
               do_send   = 1'b1;
            end
            default: begin
               phase_in = rlpf_pkg::PH_FIRST;
            end
         endcase
         // Each channel carries two packets before the hop advances.
         if (do_send) begin
            if (parity_ff) begin
               hop_in = (hop_next >= count_ff) ? '0 : hop_next[rlpf_pkg::TBL_AW-1:0];
            end
            parity_in = !parity_ff;
         end
      end
   end

   assign rd_en = req_fire && do_send;

   // Scaling stage: busy from acceptance, done in the following cycle, freed on load.
   assign b_load = a_done_ff && load_ready;

   always_comb begin
      a_busy_in = a_busy_ff;
      a_done_in = a_done_ff;
      if (b_load) begin
         a_busy_in = 1'b0;
         a_done_in = 1'b0;
      end else if (a_busy_ff) begin
         a_done_in = 1'b1;
      end
      if (req_fire && (do_send || phase_ff == rlpf_pkg::PH_FIRST)) begin
         a_busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rlpf_pkg::PH_FIRST;
         cd_ff     <= '0;
         hop_ff    <= '0;
         parity_ff <= 1'b0;
         count_ff  <= '0;
         a_busy_ff <= 1'b0;
         a_done_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cd_ff     <= cd_in;
         hop_ff    <= hop_in;
         parity_ff <= parity_in;
         count_ff  <= count_in;
         a_busy_ff <= a_busy_in;
         a_done_ff <= a_done_in;
      end
   end

   // Tick payload held for the scaling stage.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         raw_ff    <= req_tdata;
         a_kind_ff <= a_kind_in;
      end
   end

   rlpf_hop_table u_hop_table (
      .clock    (clock),
      .reset    (reset),
      .load_req (load_req),
      .rd_en    (rd_en),
      .rd_addr  (hop_ff),
      .rd_data  (rd_data),
      .busy     (tbl_busy)
   );

   rlpf_stick_scale u_stick_scale (
      .clock (clock),
      .en    (a_busy_ff && !a_done_ff),
      .raw   (raw_ff),
      .stick (stick)
   );

   always_comb begin
      build_req.kind  = a_kind_ff;
      build_req.chan  = (a_kind_ff == rlpf_pkg::KIND_FIRST) ? rlpf_pkg::FIRST_CHANNEL
                                                            : rd_data[rlpf_pkg::CHAN_W-1:0];
      build_req.mode  = mode_ff;
      build_req.flags = flags_ff;
      build_req.addr  = addr_ff;
   end

   rlpf_pkt_builder u_pkt_builder (
      .clock      (clock),
      .reset      (reset),
      .load       (b_load),
      .req        (build_req),
      .stick      (stick),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/rlpf_checker.sv @@
// Port-level checks of the RC link packet framer and their binding.
module rlpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // No packet byte can be pending in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The packet kind is always one of the defined kinds.
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rlpf_pkg::KIND_FIRST ||
                      rsp_tuser == rlpf_pkg::KIND_BIND ||
                      rsp_tuser == rlpf_pkg::KIND_DATA))
      else $error("unused packet kind");

   // The first packet always goes out on its fixed channel.
   a_first_chan: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == rlpf_pkg::KIND_FIRST)
         |-> (rsp_tdata[14:8] == rlpf_pkg::FIRST_CHANNEL))
      else $error("first packet on wrong channel");

   // A stalled byte holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

endmodule

bind rc_link_packet_framer rlpf_checker u_rlpf_checker (.*);
